// ===== sv/wbps_pkg.sv =====
// Shared constants and types for the wildcard byte pattern scanner.
// No dependencies; compiled first.
package wbps_pkg;

    // Signature depth and derived widths.
    localparam int MAX_PAT_BYTES = 16;
    localparam int WIN_IDX_W     = $clog2(MAX_PAT_BYTES);
    localparam int PAT_BITS      = 8 * MAX_PAT_BYTES;

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 5;
    localparam int MASK_W  = 16;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 3;

    // Register indexes on the configuration channel.
    typedef enum logic [CIDX_W-1:0] {
        CFG_PAT_LO    = 3'd0,
        CFG_PAT_HI    = 3'd1,
        CFG_WC_MASK   = 3'd2,
        CFG_PAT_LEN   = 3'd3,
        CFG_BASE_ADDR = 3'd4
    } t_cfg_idx;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// ===== sv/wbps_if.sv =====
// Valid/ready channel interfaces for the scanner: byte input, result output, config writes.
// Depends on wbps_pkg.
interface wbps_in_if
    import wbps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  region_last;

    modport source (output valid, output data_byte, output region_last, input ready);
    modport sink   (input valid, input data_byte, input region_last, output ready);
endinterface

interface wbps_out_if
    import wbps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              match_here;
    logic [ADDR_W-1:0] match_address;
    logic              first_match_res;
    logic              not_found;

    modport source (output valid, output match_here, output match_address,
                    output first_match_res, output not_found, input ready);
    modport sink   (input valid, input match_here, input match_address,
                    input first_match_res, input not_found, output ready);
endinterface

interface wbps_cfg_if
    import wbps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CFG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wildcard_byte_pattern_scan.sv =====
// Wildcard byte signature scanner, top level: registers, sliding window, result register.
// Depends on wbps_pkg and the channel interfaces in wbps_if.sv.
// The result is valid in the cycle after the input transfer. Throughput: one byte per cycle,
// set by the single result register; a new byte is taken whenever that register is empty
// or being drained. Reset (synchronous, active low) clears registers, window, byte count
// and found flag; no clearing pass.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wbps_cfg_if.sink    i_cfg,
    wbps_in_if.sink     i_in,
    wbps_out_if.source  o_out
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes are always accepted (ready is tied high).
    // ---------------------------------------------------------------
    logic [63:0]       r_pat_lo;
    logic [63:0]       r_pat_hi;
    logic [MASK_W-1:0] r_wc_mask;
    logic [LEN_W-1:0]  r_pat_len;
    logic [ADDR_W-1:0] r_base;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_wc_mask <= '0;
            r_pat_len <= '0;
            r_base    <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PAT_LO:    r_pat_lo  <= i_cfg.data;
                CFG_PAT_HI:    r_pat_hi  <= i_cfg.data;
                CFG_WC_MASK:   r_wc_mask <= i_cfg.data[MASK_W-1:0];
                CFG_PAT_LEN:   r_pat_len <= i_cfg.data[LEN_W-1:0];
                CFG_BASE_ADDR: r_base    <= i_cfg.data;
                default: ; // unknown index: dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the result register empties or drains this cycle.
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    t_byte             r_window [MAX_PAT_BYTES];   // entry 0 newest
    logic [ADDR_W-1:0] r_bytes_seen;               // region bytes before this one
    logic              r_found;

    // Window including the incoming byte.
    t_byte win_new [MAX_PAT_BYTES];

    always_comb begin
        win_new[0] = i_in.data_byte;
        for (int k = 1; k < MAX_PAT_BYTES; k++) begin
            win_new[k] = r_window[k-1];
        end
    end

    // Clamp length to the window depth.
    logic [LEN_W-1:0] len_c;
    assign len_c = (r_pat_len > LEN_W'(MAX_PAT_BYTES)) ? LEN_W'(MAX_PAT_BYTES) : r_pat_len;

    // Window ending here is full once bytes_seen >= len - 1.
    logic [WIN_IDX_W-1:0] len_m1;
    logic                 win_full;
    assign len_m1   = WIN_IDX_W'(len_c - LEN_W'(1));
    assign win_full = (len_c != '0) &&
                      ((|r_bytes_seen[ADDR_W-1:WIN_IDX_W]) ||
                       (r_bytes_seen[WIN_IDX_W-1:0] >= len_m1));

    // Per-position compare: signature byte k lines up with window entry len-1-k.
    logic [PAT_BITS-1:0] pat_all;
    logic                mismatch;
    logic                match_c;

    assign pat_all = PAT_BITS'({r_pat_hi, r_pat_lo});

    always_comb begin
        logic [LEN_W-1:0] j;
        mismatch = 1'b0;
        for (int k = 0; k < MAX_PAT_BYTES; k++) begin
            j = len_c - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < len_c) && !r_wc_mask[k] &&
                (win_new[j[WIN_IDX_W-1:0]] != pat_all[k*8 +: 8])) begin
                mismatch = 1'b1;
            end
        end
    end

    assign match_c = win_full && !mismatch;

    // Match start: base + bytes_seen + 1 - len, modulo 2^64.
    logic [ADDR_W-1:0] addr_c;
    assign addr_c = r_base + r_bytes_seen + ADDR_W'(1) - ADDR_W'(len_c);

    // State update on each input transfer; region_last returns to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_found      <= 1'b0;
            for (int k = 0; k < MAX_PAT_BYTES; k++) begin
                r_window[k] <= '0;
            end
        end else if (in_fire) begin
            if (i_in.region_last) begin
                r_bytes_seen <= '0;
                r_found      <= 1'b0;
                for (int k = 0; k < MAX_PAT_BYTES; k++) begin
                    r_window[k] <= '0;
                end
            end else begin
                r_bytes_seen <= r_bytes_seen + ADDR_W'(1);
                r_found      <= r_found || match_c;
                for (int k = 0; k < MAX_PAT_BYTES; k++) begin
                    r_window[k] <= win_new[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic              r_match;
    logic [ADDR_W-1:0] r_addr;
    logic              r_first;
    logic              r_nf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_match <= match_c;
            r_addr  <= match_c ? addr_c : '0;
            r_first <= match_c && !r_found;
            r_nf    <= i_in.region_last && !r_found && !match_c;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.match_here      = r_match;
    assign o_out.match_address   = r_addr;
    assign o_out.first_match_res = r_first;
    assign o_out.not_found       = r_nf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_first_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_first || r_match))
        else $error("first match flagged without a match");

    a_nf_excl_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_nf && r_match))
        else $error("not_found together with a match");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.region_last) |=> (r_bytes_seen == '0 && !r_found))
        else $error("scan state not cleared after region end");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !(in_fire && i_in.region_last)) |=> r_found)
        else $error("found flag dropped inside a region");

    a_match_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && match_c && !i_in.region_last) |=> r_found)
        else $error("match did not set found flag");

endmodule
